FILE: rtl/core/hcms_pkg.sv
// hcms_pkg: shared constants and the exp(-j/8) table for the histogram CRPS scorer.
// No dependencies; imported by the scorer and the testbench.
package hcms_pkg;

   localparam int MAX_BINS  = 64;
   localparam int IDX_W     = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int CNT_W     = $clog2(MAX_BINS + 1);
   localparam int SUM_W     = 32 + CNT_W;
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;

   localparam logic signed [MUL_W-1:0] Q30_ONE = MUL_W'(64'sd1 << 30);

   // ceil(2^33 / 3): x / 3 = (x * RECIP3) >> 33 for x below 2^32
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

   // exp(-j/8) in Q1.32, j = 0..8
   function automatic logic [32:0] exp_eighths(input logic [3:0] j);
      logic [32:0] v;
      case (j)
         4'd0:    v = 33'd4294967296;
         4'd1:    v = 33'd3790295335;
         4'd2:    v = 33'd3344923893;
         4'd3:    v = 33'd2951884975;
         4'd4:    v = 33'd2605029347;
         4'd5:    v = 33'd2298930330;
         4'd6:    v = 33'd2028798896;
         4'd7:    v = 33'd1790408741;
         4'd8:    v = 33'd1580030169;
         default: v = 33'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/core/hcms_if.sv
// hcms_req_if / hcms_rsp_if: valid-ready channels of the histogram CRPS scorer.
// No dependencies beyond the language; an item moves when valid and ready are high.
interface hcms_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] observation;
   logic signed [31:0] logit;
   logic signed [31:0] left_border;
   logic signed [31:0] right_border;
   logic               last_bin;

   modport source (output valid, func, observation, logit, left_border, right_border,
                   last_bin, input ready);
   modport sink   (input valid, func, observation, logit, left_border, right_border,
                   last_bin, output ready);
endinterface

interface hcms_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] mean_score;
   logic        empty_group;

   modport source (output valid, mean_score, empty_group, input ready);
   modport sink   (input valid, mean_score, empty_group, output ready);
endinterface

FILE: rtl/core/histogram_crps_mean_scorer.sv
// histogram_crps_mean_scorer: CRPS of histogram forecasts, averaged over a group of rows.
// Depends on hcms_pkg and the channel interfaces in hcms_if.sv.
//
// Use: req_ch carries one item per bin (func = 0): logit and left border, with the
// observation on the row's first bin and the right border on the bin marked last_bin.
// A bin is stored as its item is taken. The last bin starts scoring: a max search over
// the bins, exp of each bin (one multiply per step of exp(-1)), then per bin a 64-step
// restoring divide for the probability and a CRPS segment (none for a bin of no width);
// a bin split by the observation adds a second divide and segment.
// req_ch is not ready while a row is scored.
// A finish item (func = 1) runs the mean divide if the group has rows, then loads the
// rsp_ch register with mean_score and empty_group; the group then starts afresh.
// Bin items are taken while a result waits in rsp_ch; a further finish item holds
// until rsp_ch has been emptied. Rows longer than MAX_BINS are dropped whole.
// Reset (synchronous) empties the group, the row and rsp_ch; the bin stores are not cleared.
module histogram_crps_mean_scorer
   import hcms_pkg::*;
(
   input logic        clock,
   input logic        reset,
   hcms_req_if.sink   req_ch,
   hcms_rsp_if.source rsp_ch
);

   typedef enum logic [28:0] {
      S_IDLE     = 29'(1) << 0,
      S_RB       = 29'(1) << 1,
      S_MX_RD    = 29'(1) << 2,
      S_MX_CMP   = 29'(1) << 3,
      S_EX_RD    = 29'(1) << 4,
      S_EX_T     = 29'(1) << 5,
      S_EX_I     = 29'(1) << 6,
      S_EX_V     = 29'(1) << 7,
      S_EX_M     = 29'(1) << 8,
      S_EX_MW    = 29'(1) << 9,
      S_EX_WR    = 29'(1) << 10,
      S_SC_RD_LO = 29'(1) << 11,
      S_SC_RD_HI = 29'(1) << 12,
      S_SC_HI    = 29'(1) << 13,
      S_SC_DIVP  = 29'(1) << 14,
      S_SC_DIVU  = 29'(1) << 15,
      S_SC_MULQ  = 29'(1) << 16,
      S_SC_Q     = 29'(1) << 17,
      S_SG_AA    = 29'(1) << 18,
      S_SG_AM    = 29'(1) << 19,
      S_SG_MM    = 29'(1) << 20,
      S_SG_D3    = 29'(1) << 21,
      S_SG_D3W   = 29'(1) << 22,
      S_SG_LG    = 29'(1) << 23,
      S_SG_ADD   = 29'(1) << 24,
      S_SC_NEXT  = 29'(1) << 25,
      S_SC_FIN   = 29'(1) << 26,
      S_MEAN     = 29'(1) << 27,
      S_OUT      = 29'(1) << 28
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] logit_mem  [MAX_BINS];
   logic signed [31:0] border_mem [MAX_BINS+1];
   logic [32:0]        ex_mem     [MAX_BINS];

   logic signed [31:0] logit_rd_ff, border_rd_ff;
   logic [32:0]        ex_rd_ff;

   logic [CNT_W-1:0]   bins_ff, bins_in, k_ff, k_in;
   logic               ovf_ff, ovf_in;
   logic signed [31:0] obs_ff, obs_in, rb_ff, rb_in, mx_ff, mx_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [3:0]         n_ff, n_in;
   logic [2:0]         j_ff, j_in;
   logic [12:0]        r_ff, r_in;
   logic [32:0]        v_ff, v_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [30:0]        p_ff, p_in, u_ff, u_in, q_ff, q_in, cum_ff, cum_in;
   logic [31:0]        d_ff, d_in, e_ff, e_in, len_ff, len_in, g_ff, g_in;
   logic signed [MUL_W-1:0] a_ff, a_in, m_ff, m_in;
   logic               second_ff, second_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0]        crps_ff, crps_in, ssum_ff, ssum_in;
   logic [31:0]        rows_ff, rows_in;
   logic [32:0]        tt_ff, tt_in;

   logic [DIV_W-1:0]     dquo_ff, dquo_in, drem_ff, drem_in, dden_ff, dden_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic                 div_start, div_done;
   logic [DIV_W-1:0]     div_dvd, div_dvs;
   logic [DIV_W:0]       rem_sh, rem_diff;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in, empty_ff, empty_in;
   logic [31:0] mean_ff, mean_in;

   logic               logit_we, border_we, ex_we;
   logic [CNT_W-1:0]   border_wa, border_ra;
   logic signed [31:0] border_wd;

   logic [CNT_W-1:0]   bins_nx;
   logic               ovf_nx, last_idx;
   logic signed [32:0] wid, ex_t, br_y_lo, br_hi_y;
   logic signed [63:0] br;
   logic [64:0]        ssum_add;
   logic [30:0]        d3_s;
   logic [1:0]         d3_t;

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.mean_score  = mean_ff;
   assign rsp_ch.empty_group = empty_ff;

   assign last_idx  = ((CNT_W'(idx_ff) + CNT_W'(1)) == k_ff);
   assign wid       = {hi_ff[31], hi_ff} - {lo_ff[31], lo_ff};
   assign br_y_lo   = {obs_ff[31], obs_ff} - {lo_ff[31], lo_ff};
   assign br_hi_y   = {hi_ff[31], hi_ff} - {obs_ff[31], obs_ff};
   assign ex_t      = {mx_ff[31], mx_ff} - {logit_rd_ff[31], logit_rd_ff};
   assign d3_s      = prod_ff[63:33];
   assign d3_t      = m_ff[1:0] - (d3_s[1:0] + {d3_s[0], 1'b0});
   assign br        = acc_ff + $signed(prod_ff[63:0]) + $signed({prod_ff[62:0], 1'b0})
                      + $signed({31'b0, tt_ff});
   assign ssum_add  = {1'b0, ssum_ff} + {1'b0, crps_ff};
   assign border_ra = (state_ff == S_SC_RD_HI) ? CNT_W'(idx_ff) + CNT_W'(1) : CNT_W'(idx_ff);
   assign div_done  = (dcnt_ff == '0);
   assign rem_sh    = {drem_ff, dquo_ff[DIV_W-1]};
   assign rem_diff  = rem_sh - {1'b0, dden_ff};
   assign prod_in   = mul_a * mul_b;

   always_comb begin
      state_in  = state_ff;
      bins_in   = bins_ff;
      ovf_in    = ovf_ff;
      k_in      = k_ff;
      obs_in    = obs_ff;
      rb_in     = rb_ff;
      mx_in     = mx_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      j_in      = j_ff;
      r_in      = r_ff;
      v_in      = v_ff;
      sum_in    = sum_ff;
      p_in      = p_ff;
      u_in      = u_ff;
      q_in      = q_ff;
      cum_in    = cum_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      len_in    = len_ff;
      g_in      = g_ff;
      a_in      = a_ff;
      m_in      = m_ff;
      second_in = second_ff;
      acc_in    = acc_ff;
      crps_in   = crps_ff;
      ssum_in   = ssum_ff;
      rows_in   = rows_ff;
      tt_in     = tt_ff;
      mean_in   = mean_ff;
      empty_in  = empty_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      logit_we  = 1'b0;
      border_we = 1'b0;
      ex_we     = 1'b0;
      border_wa = bins_ff;
      border_wd = req_ch.left_border;
      div_start = 1'b0;
      div_dvd   = '0;
      div_dvs   = '0;
      mul_a     = '0;
      mul_b     = '0;
      bins_nx   = bins_ff;
      ovf_nx    = ovf_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.func) begin
                  bins_in = '0;
                  ovf_in  = 1'b0;
                  if (rows_ff != '0) begin
                     div_start = 1'b1;
                     div_dvd   = ssum_ff;
                     div_dvs   = DIV_W'(rows_ff);
                     state_in  = S_MEAN;
                  end else begin
                     state_in = S_OUT;
                  end
               end else begin
                  if (bins_ff == '0) begin
                     obs_in = req_ch.observation;
                  end
                  if (bins_ff < CNT_W'(MAX_BINS)) begin
                     logit_we  = 1'b1;
                     border_we = 1'b1;
                     bins_nx   = bins_ff + CNT_W'(1);
                  end else begin
                     ovf_nx = 1'b1;
                  end
                  bins_in = bins_nx;
                  ovf_in  = ovf_nx;
                  if (req_ch.last_bin) begin
                     bins_in = '0;
                     ovf_in  = 1'b0;
                     if (!ovf_nx) begin
                        k_in     = bins_nx;
                        rb_in    = req_ch.right_border;
                        state_in = S_RB;
                     end
                  end
               end
            end
         end
         S_RB: begin
            border_we = 1'b1;
            border_wa = k_ff;
            border_wd = rb_ff;
            idx_in    = '0;
            state_in  = S_MX_RD;
         end
         S_MX_RD: begin
            state_in = S_MX_CMP;
         end
         S_MX_CMP: begin
            if (idx_ff == '0 || logit_rd_ff > mx_ff) begin
               mx_in = logit_rd_ff;
            end
            if (last_idx) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = S_EX_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_MX_RD;
            end
         end
         S_EX_RD: begin
            state_in = S_EX_T;
         end
         S_EX_T: begin
            n_in = ex_t[19:16];
            j_in = ex_t[15:13];
            r_in = ex_t[12:0];
            if (ex_t[32:20] != '0) begin
               v_in     = '0;
               state_in = S_EX_WR;
            end else begin
               state_in = S_EX_I;
            end
         end
         S_EX_I: begin
            mul_a    = $signed({1'b0, exp_eighths({1'b0, j_ff})
                                    - exp_eighths({1'b0, j_ff} + 4'd1)});
            mul_b    = $signed({21'b0, r_ff});
            state_in = S_EX_V;
         end
         S_EX_V: begin
            v_in     = exp_eighths({1'b0, j_ff}) - prod_ff[45:13];
            state_in = (n_ff == '0) ? S_EX_WR : S_EX_M;
         end
         S_EX_M: begin
            mul_a    = $signed({1'b0, v_ff});
            mul_b    = $signed({1'b0, exp_eighths(4'd8)});
            state_in = S_EX_MW;
         end
         S_EX_MW: begin
            v_in     = prod_ff[64:32];
            n_in     = n_ff - 4'd1;
            state_in = (n_ff == 4'd1) ? S_EX_WR : S_EX_M;
         end
         S_EX_WR: begin
            ex_we  = 1'b1;
            sum_in = sum_ff + SUM_W'(v_ff);
            if (last_idx) begin
               idx_in   = '0;
               cum_in   = '0;
               crps_in  = '0;
               state_in = S_SC_RD_LO;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_EX_RD;
            end
         end
         S_SC_RD_LO: begin
            state_in = S_SC_RD_HI;
         end
         S_SC_RD_HI: begin
            lo_in     = border_rd_ff;
            div_start = 1'b1;
            div_dvd   = {ex_rd_ff, 31'b0} >> 1;
            div_dvs   = DIV_W'(sum_ff);
            state_in  = S_SC_HI;
         end
         S_SC_HI: begin
            hi_in    = border_rd_ff;
            state_in = S_SC_DIVP;
         end
         S_SC_DIVP: begin
            if (div_done) begin
               p_in      = dquo_ff[30:0];
               m_in      = $signed({3'b0, dquo_ff[30:0]});
               len_in    = wid[31:0];
               second_in = 1'b0;
               d_in      = br_y_lo[31:0];
               e_in      = br_hi_y[31:0];
               if (wid <= 33'sd0) begin
                  state_in = S_SC_NEXT;
               end else if (obs_ff < lo_ff) begin
                  a_in     = $signed({3'b0, cum_ff}) - Q30_ONE;
                  state_in = S_SG_AA;
               end else if (obs_ff > hi_ff) begin
                  a_in     = $signed({3'b0, cum_ff});
                  state_in = S_SG_AA;
               end else begin
                  div_start = 1'b1;
                  div_dvd   = DIV_W'({br_y_lo[31:0], 30'b0});
                  div_dvs   = DIV_W'(wid[31:0]);
                  state_in  = S_SC_DIVU;
               end
            end
         end
         S_SC_DIVU: begin
            if (div_done) begin
               u_in     = dquo_ff[30:0];
               state_in = S_SC_MULQ;
            end
         end
         S_SC_MULQ: begin
            mul_a    = $signed({3'b0, p_ff});
            mul_b    = $signed({3'b0, u_ff});
            state_in = S_SC_Q;
         end
         S_SC_Q: begin
            q_in      = prod_ff[60:30];
            a_in      = $signed({3'b0, cum_ff});
            m_in      = $signed({3'b0, prod_ff[60:30]});
            len_in    = d_ff;
            second_in = 1'b1;
            state_in  = S_SG_AA;
         end
         S_SG_AA: begin
            mul_a    = a_ff;
            mul_b    = a_ff;
            state_in = S_SG_AM;
         end
         S_SG_AM: begin
            acc_in   = prod_ff[63:0];
            mul_a    = a_ff;
            mul_b    = m_ff;
            state_in = S_SG_MM;
         end
         S_SG_MM: begin
            acc_in   = acc_ff + prod_ff[63:0];
            mul_a    = $signed({3'b0, m_ff[30:0]});
            mul_b    = $signed({2'b0, RECIP3});
            state_in = S_SG_D3;
         end
         S_SG_D3: begin
            // m = 3s + t: floor(m*m/3) = 3*s*s + 2*s*t + (t == 2)
            if (d3_t == 2'd1) begin
               tt_in = {1'b0, d3_s, 1'b0};
            end else if (d3_t == 2'd2) begin
               tt_in = {d3_s, 2'b0} + 33'd1;
            end else begin
               tt_in = '0;
            end
            mul_a    = $signed({3'b0, d3_s});
            mul_b    = $signed({3'b0, d3_s});
            state_in = S_SG_D3W;
         end
         S_SG_D3W: begin
            g_in     = (br < 64'sd0) ? 32'd0 : br[61:30];
            state_in = S_SG_LG;
         end
         S_SG_LG: begin
            mul_a    = $signed({2'b0, len_ff});
            mul_b    = $signed({2'b0, g_ff});
            state_in = S_SG_ADD;
         end
         S_SG_ADD: begin
            crps_in = crps_ff + {30'b0, prod_ff[63:30]};
            if (second_ff) begin
               second_in = 1'b0;
               a_in      = $signed({3'b0, cum_ff}) + $signed({3'b0, q_ff}) - Q30_ONE;
               m_in      = $signed({3'b0, p_ff}) - $signed({3'b0, q_ff});
               len_in    = e_ff;
               state_in  = S_SG_AA;
            end else begin
               state_in = S_SC_NEXT;
            end
         end
         S_SC_NEXT: begin
            cum_in = cum_ff + p_ff;
            if (last_idx) begin
               state_in = S_SC_FIN;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SC_RD_LO;
            end
         end
         S_SC_FIN: begin
            ssum_in  = ssum_add[64] ? '1 : ssum_add[63:0];
            rows_in  = (rows_ff == '1) ? rows_ff : rows_ff + 32'd1;
            state_in = S_IDLE;
         end
         S_MEAN: begin
            if (div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               empty_in     = (rows_ff == '0);
               if (rows_ff == '0) begin
                  mean_in = '0;
               end else if (dquo_ff[63:32] != '0) begin
                  mean_in = '1;
               end else begin
                  mean_in = dquo_ff[31:0];
               end
               ssum_in  = '0;
               rows_in  = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      dquo_in = dquo_ff;
      drem_in = drem_ff;
      dden_in = dden_ff;
      dcnt_in = dcnt_ff;
      if (div_start) begin
         dquo_in = div_dvd;
         drem_in = '0;
         dden_in = div_dvs;
         dcnt_in = DIV_CNT_W'(DIV_W);
      end else if (!div_done) begin
         drem_in = rem_diff[DIV_W] ? rem_sh[DIV_W-1:0] : rem_diff[DIV_W-1:0];
         dquo_in = {dquo_ff[DIV_W-2:0], ~rem_diff[DIV_W]};
         dcnt_in = dcnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bins_ff      <= '0;
         ovf_ff       <= 1'b0;
         obs_ff       <= '0;
         ssum_ff      <= '0;
         rows_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         bins_ff      <= bins_in;
         ovf_ff       <= ovf_in;
         obs_ff       <= obs_in;
         ssum_ff      <= ssum_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      rb_ff     <= rb_in;
      mx_ff     <= mx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      n_ff      <= n_in;
      j_ff      <= j_in;
      r_ff      <= r_in;
      v_ff      <= v_in;
      sum_ff    <= sum_in;
      p_ff      <= p_in;
      u_ff      <= u_in;
      q_ff      <= q_in;
      cum_ff    <= cum_in;
      d_ff      <= d_in;
      e_ff      <= e_in;
      len_ff    <= len_in;
      g_ff      <= g_in;
      a_ff      <= a_in;
      m_ff      <= m_in;
      second_ff <= second_in;
      acc_ff    <= acc_in;
      crps_ff   <= crps_in;
      tt_ff     <= tt_in;
      mean_ff   <= mean_in;
      empty_ff  <= empty_in;
      dquo_ff   <= dquo_in;
      drem_ff   <= drem_in;
      dden_ff   <= dden_in;
      prod_ff   <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (logit_we) begin
         logit_mem[bins_ff[IDX_W-1:0]] <= req_ch.logit;
      end
      logit_rd_ff <= logit_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (border_we) begin
         border_mem[border_wa] <= border_wd;
      end
      border_rd_ff <= border_mem[border_ra];
   end

   always_ff @(posedge clock) begin
      if (ex_we) begin
         ex_mem[idx_ff] <= v_ff;
      end
      ex_rd_ff <= ex_mem[idx_ff];
   end

`ifndef ASSERT_OFF
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result register loaded outside the output state");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> div_done)
      else $error("divider restarted while busy");

   a_bins_bound: assert property (@(posedge clock) disable iff (reset)
      bins_ff <= CNT_W'(MAX_BINS))
      else $error("bin count beyond store depth");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && empty_ff |-> mean_ff == '0)
      else $error("empty group with non-zero mean");
`endif

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for histogram_crps_mean_scorer.
// Depends on hcms_pkg and the channel interfaces in hcms_if.sv; predicts each group mean
// in software, drives bin and finish items with random idling and checks every result.
module tb
   import hcms_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES   = 3000;

   typedef struct packed {
      logic [31:0] mean_score;
      logic        empty_group;
   } group_result_type;

   logic clock;
   logic reset;

   hcms_req_if req_ch ();
   hcms_rsp_if rsp_ch ();

   histogram_crps_mean_scorer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // own copy of the block state
   logic signed [31:0] row_logits [MAX_BINS];
   logic signed [31:0] row_borders [MAX_BINS + 1];
   logic signed [31:0] row_observation;
   int unsigned        row_fill;
   logic               row_too_long;
   logic [63:0]        group_sum;
   logic [31:0]        group_rows;

   group_result_type   pending_means [$];
   int                 mismatches;
   int                 means_checked;
   int                 items_sent;
   int                 rows_sent;
   int                 idle_pct;
   int                 stall_pct;
   int                 hold_cycles;
   int                 quiet_cycles;

   logic [63:0] exp_table [9] = '{
      64'd4294967296, 64'd3790295335, 64'd3344923893, 64'd2951884975, 64'd2605029347,
      64'd2298930330, 64'd2028798896, 64'd1790408741, 64'd1580030169
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] exp_neg(logic [63:0] t);
      logic [63:0] v;
      int          j;
      logic [63:0] r;
      if (t >= (64'd16 << 16)) return 64'd0;
      j = int'(t[15:13]);
      r = 64'(t[12:0]);
      v = exp_table[j] - (((exp_table[j] - exp_table[j+1]) * r) >> 13);
      for (int k = 0; k < int'(t[63:16]); k++) v = (v * exp_table[8]) >> 32;
      return v;
   endfunction

   function automatic logic [63:0] segment_crps(logic [63:0] len, longint a, longint m);
      longint      br;
      logic [63:0] g;
      br = a * a + a * m + (m * m) / 3;
      if (br < 0) br = 0;
      g = 64'(br) >> 30;
      return (len * g) >> 30;
   endfunction

   function automatic logic [63:0] row_crps(int unsigned k);
      logic [63:0] ex [MAX_BINS];
      logic [63:0] total, crps, d, e, u;
      longint      mx, y, cum, lo, hi, w, p, q;
      mx = row_logits[0];
      for (int i = 1; i < k; i++) if (longint'(row_logits[i]) > mx) mx = row_logits[i];
      total = 0;
      for (int i = 0; i < k; i++) begin
         ex[i] = exp_neg(64'(mx - longint'(row_logits[i])));
         total += ex[i];
      end
      if (total == 0) return 64'd0;
      y    = row_observation;
      cum  = 0;
      crps = 0;
      for (int i = 0; i < k; i++) begin
         lo = row_borders[i];
         hi = row_borders[i+1];
         w  = hi - lo;
         p  = longint'((ex[i] << 30) / total);
         if (w > 0) begin
            if (y < lo) begin
               crps += segment_crps(64'(w), cum - (64'sd1 << 30), p);
            end else if (y > hi) begin
               crps += segment_crps(64'(w), cum, p);
            end else begin
               d = 64'(y - lo);
               e = 64'(hi - y);
               u = (d << 30) / 64'(w);
               q = longint'((64'(p) * u) >> 30);
               crps += segment_crps(d, cum, q);
               crps += segment_crps(e, cum + q - (64'sd1 << 30), p - q);
            end
         end
         cum += p;
      end
      return crps;
   endfunction

   function automatic void predict_item(logic func, logic signed [31:0] obs,
                                        logic signed [31:0] logit, logic signed [31:0] lb,
                                        logic signed [31:0] rb, logic last);
      group_result_type res;
      logic [63:0]      s, mean;
      if (func) begin
         mean = 0;
         if (group_rows != 0) begin
            mean = group_sum / 64'(group_rows);
            if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
         end
         res.mean_score  = mean[31:0];
         res.empty_group = (group_rows == 0);
         pending_means.push_back(res);
         group_sum    = 0;
         group_rows   = 0;
         row_fill     = 0;
         row_too_long = 1'b0;
         return;
      end
      if (row_fill == 0) row_observation = obs;
      if (row_fill < MAX_BINS) begin
         row_logits[row_fill]  = logit;
         row_borders[row_fill] = lb;
         row_fill++;
      end else begin
         row_too_long = 1'b1;
      end
      if (last) begin
         if (!row_too_long && row_fill > 0) begin
            row_borders[row_fill] = rb;
            s = row_crps(row_fill);
            group_sum = (group_sum > ~64'd0 - s) ? ~64'd0 : group_sum + s;
            if (group_rows != 32'hFFFF_FFFF) group_rows++;
         end
         row_fill     = 0;
         row_too_long = 1'b0;
      end
   endfunction

   task automatic send_item(logic func, logic signed [31:0] obs, logic signed [31:0] logit,
                            logic signed [31:0] lb, logic signed [31:0] rb, logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.observation  <= obs;
      req_ch.logit        <= logit;
      req_ch.left_border  <= lb;
      req_ch.right_border <= rb;
      req_ch.last_bin     <= last;
      do @(posedge clock); while (!req_ch.ready);
      predict_item(func, obs, logit, lb, rb, last);
      items_sent++;
   endtask

   task automatic send_finish();
      send_item(1'b1, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
   endtask

   // one row of k bins; left borders ordered with random step unless scrambled, right border random
   task automatic send_row(int k, logic scrambled, logic signed [31:0] obs,
                           logic signed [31:0] logit_span, logic signed [31:0] start,
                           int unsigned step_max);
      logic signed [31:0] b;
      b = start;
      for (int i = 0; i < k; i++) begin
         send_item(1'b0, (i == 0) ? obs : $urandom,
                   scrambled ? $urandom : $signed($urandom_range(logit_span)) - logit_span / 2,
                   scrambled ? $urandom : b, $urandom + step_max, 1'b0 | (i == k - 1));
         if (i == k - 1) break;
         b = b + $signed($urandom_range(step_max));
      end
      rows_sent++;
   endtask

   task automatic send_row_closed(int k, logic signed [31:0] obs, logic signed [31:0] lo,
                                  int unsigned step, logic signed [31:0] rb,
                                  logic signed [31:0] logit);
      for (int i = 0; i < k; i++)
         send_item(1'b0, obs, logit, lo + $signed(step * i), rb, i == k - 1);
      rows_sent++;
   endtask

   task automatic test_empty_group();
      send_finish();
      send_finish();
   endtask

   task automatic test_observation_position();
      // single bin: split, left of, right of; then three bins split in the first
      send_row_closed(1, 32'sh0001_8000, 32'sh0001_0000, 1, 32'sh0002_0000, 0);
      send_row_closed(1, -32'sh0005_0000, 32'sh0001_0000, 1, 32'sh0002_0000, 0);
      send_row_closed(1, 32'sh0009_0000, 32'sh0001_0000, 1, 32'sh0002_0000, 0);
      send_row_closed(3, 32'sh0000_4000, 32'sh0000_0000, 32'h0000_8000, 32'sh0001_8000,
                      32'sh7FFF_FFFF);
      send_finish();
   endtask

   task automatic test_widths_and_extremes();
      // zero width, extreme logits and borders
      send_row_closed(2, 0, 32'sh0001_0000, 0, 32'sh0001_0000, 0);
      send_item(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      send_item(1'b0, 0, 32'sh8000_0000, 32'sh7FFF_0000, 32'sh7FFF_FFFF, 1'b1);
      send_item(1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
      send_item(1'b0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
      send_item(1'b0, 0, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
      send_item(1'b0, 0, 32'sh000F_FFFF, 32'sh0001_0000, 32'sh0002_0000, 1'b1);
      rows_sent += 4;
      send_finish();
   endtask

   task automatic test_row_length();
      send_row(MAX_BINS, 1'b0, 32'sh0010_0000, 32'sh0004_0000, 0, 32'h0000_8000);
      send_row(MAX_BINS + 3, 1'b0, 0, 32'sh0004_0000, 0, 32'h0000_8000);
      send_finish();
      // finish during a row
      send_item(1'b0, 0, 0, 0, 32'sh0001_0000, 1'b0);
      send_finish();
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      send_row(2, 1'b0, 0, 32'sh0002_0000, 0, 32'h0001_0000);
      send_finish();
      send_row(2, 1'b0, 0, 32'sh0002_0000, 0, 32'h0001_0000);
      send_finish();
      send_row(1, 1'b0, 0, 32'sh0002_0000, 0, 32'h0001_0000);
      send_finish();
   endtask

   task automatic test_random(int n_items, int idle, int stall);
      int stop_at, k, pick;
      idle_pct  = idle;
      stall_pct = stall;
      stop_at   = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 2) begin
            send_row(MAX_BINS + $urandom_range(4), 1'b1, $urandom, 0, 0, 0);
         end else if (pick < 12) begin
            send_row($urandom_range(1, 5), 1'b1, $urandom, 0, 0, 0);
         end else if (pick < 17) begin
            send_item(1'b0, $urandom, $urandom, $urandom, $urandom, 1'b0);
            send_finish();
         end else if (pick < 37) begin
            send_finish();
         end else begin
            k = ($urandom_range(9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            send_row(k, 1'b0, $signed($urandom_range(32'h0040_0000)) - 32'sh0010_0000,
                     ($urandom_range(3) == 0) ? 32'sh7FFF_FFFF : 32'sh0008_0000,
                     $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000,
                     ($urandom_range(7) == 0) ? 32'h1000_0000 : 32'h0002_0000);
         end
      end
      send_finish();
   endtask

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // result checker and receiver idling
   always @(posedge clock) begin
      group_result_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            means_checked++;
            if (pending_means.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: mean_score=%h empty_group=%b",
                           rsp_ch.mean_score, rsp_ch.empty_group);
            end else begin
               want = pending_means.pop_front();
               if (rsp_ch.mean_score !== want.mean_score ||
                   rsp_ch.empty_group !== want.empty_group) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: mean_score exp %h got %h, empty_group exp %b got %b",
                              want.mean_score, rsp_ch.mean_score, want.empty_group,
                              rsp_ch.empty_group);
               end
            end
         end
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", quiet_cycles);
         $display("** histogram_crps_mean_scorer: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = 1'b0;
      req_ch.observation  = '0;
      req_ch.logit        = '0;
      req_ch.left_border  = '0;
      req_ch.right_border = '0;
      req_ch.last_bin     = 1'b0;
      rsp_ch.ready        = 1'b0;
      row_fill            = 0;
      row_too_long        = 1'b0;
      row_observation     = '0;
      group_sum           = '0;
      group_rows          = '0;
      mismatches          = 0;
      means_checked       = 0;
      items_sent          = 0;
      rows_sent           = 0;
      idle_pct            = 0;
      stall_pct           = 0;
      hold_cycles         = 0;
      quiet_cycles        = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_group();
      test_observation_position();
      idle_pct  = 30;
      stall_pct = 30;
      test_widths_and_extremes();
      test_row_length();
      test_backpressure();
      test_random(345, 0, 0);
      test_random(345, 66, 0);
      test_random(345, 0, 66);
      test_random(345, 15, 15);

      req_ch.valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items in %0d rows; checked %0d group means, %0d mismatches",
               items_sent, rows_sent, means_checked, mismatches);
      if (mismatches == 0 && pending_means.size() == 0)
         $display("** histogram_crps_mean_scorer: PASSED **");
      else
         $display("** histogram_crps_mean_scorer: FAILED **");
      $finish;
   end

endmodule
